### hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	// Default sizes
	localparam int SWM_MAX_WINDOW  = 5;
	localparam int SWM_SAMPLE_BITS = 16;

	// Window length register
	localparam int          LEN_REG_BITS = 3;
	localparam logic [2:0]  LEN_RESET    = 3'd5;

	// Flags handed from one cell to its right neighbor
	typedef struct packed {
		logic removed;   // the oldest entry sits in this cell or one to its left
		logic x_before;  // the new sample ranks before this cell's compacted entry
	} swm_link_t;

endpackage

### hw/rtl/swm_if.sv
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready stream interfaces for the sample and median channels.
// ----------------------------------------------------------------------------
interface swm_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

### hw/rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One rank of the sorted window: holds a sample and its age, and on each
// transaction takes the entry that belongs at its rank after the oldest entry
// is dropped and the new sample is inserted.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_BITS    = 3,
	parameter int CELL_INDEX  = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          clear,
	input  logic                          active,
	input  logic                          last,
	input  logic [AGE_BITS-1:0]           len_m1,
	input  logic signed [SAMPLE_BITS-1:0] x,
	// compacted entry and flags of the left neighbor
	input  logic signed [SAMPLE_BITS-1:0] left_val,
	input  logic [AGE_BITS-1:0]           left_age,
	input  swm_pkg::swm_link_t            left_link,
	// stored entry of the right neighbor
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	input  logic [AGE_BITS-1:0]           right_age,
	// to the neighbors
	output logic signed [SAMPLE_BITS-1:0] val_q,
	output logic [AGE_BITS-1:0]           age_q,
	output logic signed [SAMPLE_BITS-1:0] cmp_val,
	output logic [AGE_BITS-1:0]           cmp_age,
	output swm_pkg::swm_link_t            link,
	output logic signed [SAMPLE_BITS-1:0] next_val
);
	import swm_pkg::*;

	logic                oldest;
	logic [AGE_BITS-1:0] next_age;

	// Compact: once the oldest entry is at or left of here, pull from the right
	assign oldest       = active && (age_q == len_m1);
	assign link.removed = left_link.removed | oldest;
	assign cmp_val      = link.removed ? right_val : val_q;
	assign cmp_age      = link.removed ? right_age : age_q;
	assign link.x_before = last | (x < cmp_val);

	// Insert: keep own entry, take the new sample, or shift in from the left
	always_comb begin
		if (!link.x_before) begin
			next_val = cmp_val;
			next_age = cmp_age + 1'b1;
		end else if (!left_link.x_before) begin
			next_val = x;
			next_age = '0;
		end else begin
			next_val = left_val;
			next_age = left_age + 1'b1;
		end
	end

	// Entry register; clear puts zeros with distinct ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AGE_BITS'(CELL_INDEX);
		end else if (clear) begin
			val_q <= '0;
			age_q <= AGE_BITS'(CELL_INDEX);
		end else if (load && active) begin
			val_q <= next_val;
			age_q <= next_age;
		end
	end

endmodule

### hw/rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the most recent samples, window length 1 to MAX_WINDOW.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle and returns the median of the window
// in the cycle after the sample is taken; a stalled output holds the input off
// only while its single output register is full and not being drained. The
// window is a row of MAX_WINDOW cells kept in ascending order, each with the
// age of its sample; each transaction drops the oldest entry and inserts the new
// sample in all cells at once, so the flag that marks the dropped entry
// ripples across the row and sets the clock limit. The median is the entry at
// rank length/2 (upper middle for even lengths). Writing the window length
// clears the window to zeros; no item may be in flight during that write.
// ----------------------------------------------------------------------------
module sliding_window_median #(
	parameter int MAX_WINDOW  = swm_pkg::SWM_MAX_WINDOW,
	parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swm_pkg::LEN_REG_BITS-1:0]  cfg_wdata,
	swm_sample_if.sink                        samples,
	swm_median_if.source                      medians
);
	import swm_pkg::*;

	localparam int AGE_BITS = $clog2(MAX_WINDOW);
	localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
	localparam int CMP_BITS = (LEN_BITS > LEN_REG_BITS) ? LEN_BITS : LEN_REG_BITS;

	logic [LEN_REG_BITS-1:0]        len_q;
	logic [LEN_BITS-1:0]            eff_len;
	logic [AGE_BITS-1:0]            len_m1;
	logic [AGE_BITS-1:0]            half_idx;
	logic                           accept;
	logic                           out_valid_q;
	logic signed [SAMPLE_BITS-1:0]  median_q;

	logic signed [SAMPLE_BITS-1:0]  val_q    [MAX_WINDOW];
	logic [AGE_BITS-1:0]            age_q    [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0]  cmp_val  [MAX_WINDOW];
	logic [AGE_BITS-1:0]            cmp_age  [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0]  next_val [MAX_WINDOW];
	swm_link_t                      link     [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]          active;
	logic [MAX_WINDOW-1:0]          last;
	logic [MAX_WINDOW-1:0]          oldest_vec;

	// Window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// Effective length, saturated to 1..MAX_WINDOW
	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (CMP_BITS'(len_q) > CMP_BITS'(MAX_WINDOW)) begin
			eff_len = LEN_BITS'(MAX_WINDOW);
		end else begin
			eff_len = LEN_BITS'(len_q);
		end
	end

	assign len_m1   = AGE_BITS'(eff_len - 1'b1);
	assign half_idx = AGE_BITS'(eff_len >> 1);

	// Handshake: output register is the only buffer
	assign samples.ready = !out_valid_q || medians.ready;
	assign accept        = samples.valid && samples.ready;

	// Cell row
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] l_val;
		logic [AGE_BITS-1:0]           l_age;
		swm_link_t                     l_link;
		logic signed [SAMPLE_BITS-1:0] r_val;
		logic [AGE_BITS-1:0]           r_age;

		assign active[i]     = LEN_BITS'(i) < eff_len;
		assign last[i]       = LEN_BITS'(i) == (eff_len - 1'b1);
		assign oldest_vec[i] = active[i] && (age_q[i] == len_m1);

		if (i == 0) begin : g_left_edge
			assign l_val  = '0;
			assign l_age  = '0;
			assign l_link = '0;
		end else begin : g_left
			assign l_val  = cmp_val[i-1];
			assign l_age  = cmp_age[i-1];
			assign l_link = link[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_right_edge
			assign r_val = '0;
			assign r_age = '0;
		end else begin : g_right
			assign r_val = val_q[i+1];
			assign r_age = age_q[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_BITS    (AGE_BITS),
			.CELL_INDEX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (accept),
			.clear     (cfg_we),
			.active    (active[i]),
			.last      (last[i]),
			.len_m1    (len_m1),
			.x         (samples.sample),
			.left_val  (l_val),
			.left_age  (l_age),
			.left_link (l_link),
			.right_val (r_val),
			.right_age (r_age),
			.val_q     (val_q[i]),
			.age_q     (age_q[i]),
			.cmp_val   (cmp_val[i]),
			.cmp_age   (cmp_age[i]),
			.link      (link[i]),
			.next_val  (next_val[i])
		);
	end

	// Output register: median is the updated entry at rank length/2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= next_val[half_idx];
		end
	end

	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	// Checks ---------------------------------------------------------------
	logic [MAX_WINDOW-1:0] sorted_ok;
	logic [MAX_WINDOW-1:0] zero_ok;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_chk
		if (i == MAX_WINDOW - 1) begin : g_end
			assign sorted_ok[i] = 1'b1;
		end else begin : g_pair
			assign sorted_ok[i] = !active[i+1] || (val_q[i] <= val_q[i+1]);
		end
		assign zero_ok[i] = !active[i] || (val_q[i] == '0);
	end

	// exactly one active cell holds the oldest sample
	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(oldest_vec))
		else $error("oldest entry not unique");

	// active cells stay in ascending order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&sorted_ok)
		else $error("window out of order");

	// a length write leaves an all-zero window
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> &zero_ok)
		else $error("window not cleared after length write");

	// every taken sample produces a pending median
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("median missing after transaction");

endmodule
